### rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/i2cms_pkg.sv
package i2cms_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;
    localparam int IQ_DEPTH         = 2;
    localparam int OQ_DEPTH         = 4;
    localparam int READ_MAX         = 32;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;

    localparam logic [7:0] SC_START_SENT = 8'h08;
    localparam logic [7:0] SC_SLAW_ACK   = 8'h18;
    localparam logic [7:0] SC_DATA_ACK   = 8'h28;
    localparam logic [7:0] SC_SLAR_ACK   = 8'h40;
    localparam logic [7:0] SC_RX_ACK     = 8'h50;
    localparam logic [7:0] SC_RX_NACK    = 8'h58;

    localparam logic [1:0] ACK_NONE     = 2'd0;
    localparam logic [1:0] ACK_ASSERT   = 2'd1;
    localparam logic [1:0] ACK_WITHDRAW = 2'd2;

    localparam logic [1:0] OUT_IDLE  = 2'd0;
    localparam logic [1:0] OUT_BUSY  = 2'd1;
    localparam logic [1:0] OUT_DONE  = 2'd2;
    localparam logic [1:0] OUT_ERROR = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_START,
        OP_EVENT,
        OP_NONE
    } t_op;

    typedef enum logic [2:0] {
        EV_START,
        EV_TX,
        EV_RX_ADDR,
        EV_RX_DATA,
        EV_RX_LAST,
        EV_OTHER
    } t_event;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_BUSY  = 4'b0010,
        S_DONE  = 4'b0100,
        S_ERROR = 4'b1000
    } t_state;

    // Classified item as it travels from front to back.
    typedef struct packed {
        t_op          op;
        logic         load_ok;
        logic [4:0]   tx_slot;
        logic [7:0]   tx_byte;
        logic [6:0]   address;
        logic [5:0]   write_count;
        logic [5:0]   read_count;
        t_event       evt;
        logic [7:0]   rx_byte;
    } t_cmd;

    typedef struct packed {
        logic         start_accepted;
        logic         request_start;
        logic         clear_start;
        logic         send_valid;
        logic [7:0]   send_byte;
        logic         request_stop;
        logic [1:0]   ack_action;
        logic         rx_valid;
        logic [7:0]   rx_byte;
        logic [4:0]   rx_index;
        logic [1:0]   outcome;
    } t_result;

    function automatic logic [1:0] outcome_of(input t_state s);
        logic [1:0] o;
        case (s)
            S_IDLE:  o = OUT_IDLE;
            S_BUSY:  o = OUT_BUSY;
            S_DONE:  o = OUT_DONE;
            S_ERROR: o = OUT_ERROR;
            default: o = OUT_IDLE;
        endcase
        return o;
    endfunction

endpackage

### rtl/core/i2c_master_transaction_sequencer.sv
// Items go through the command queue, execute stage, second stage and result queue.
// Throughput: one item per cycle while not full; the command queue decouples intake
// from execution, and the execute stage issues while the result queue has room for it.
// Buffered write bytes come from a registered-read RAM, merged in the second stage.
// Reset (i_rst_n low at a clock edge) empties both queues and returns the status to
// idle with lengths and address cleared; the write buffer keeps its contents.
module i2c_master_transaction_sequencer import i2cms_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_kind,
    input  logic [4:0] i_tx_slot,
    input  logic [7:0] i_tx_byte,
    input  logic [6:0] i_target_address,
    input  logic [5:0] i_write_length,
    input  logic [5:0] i_read_length,
    input  logic [7:0] i_status_code,
    input  logic [7:0] i_received_byte,
    output logic       empty,
    input  logic       pop,
    output logic       o_start_accepted,
    output logic       o_request_start,
    output logic       o_clear_start,
    output logic       o_send_valid,
    output logic [7:0] o_send_byte,
    output logic       o_request_stop,
    output logic [1:0] o_ack_action,
    output logic       o_rx_valid,
    output logic [7:0] o_rx_byte,
    output logic [4:0] o_rx_index,
    output logic [1:0] o_outcome
);

    t_cmd    cmd;
    logic    cmd_empty, cmd_pop;
    t_result result;

    i2cms_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_kind           (i_kind),
        .i_tx_slot        (i_tx_slot),
        .i_tx_byte        (i_tx_byte),
        .i_target_address (i_target_address),
        .i_write_length   (i_write_length),
        .i_read_length    (i_read_length),
        .i_status_code    (i_status_code),
        .i_received_byte  (i_received_byte),
        .i_pop            (cmd_pop),
        .o_cmd            (cmd),
        .o_empty          (cmd_empty)
    );

    i2cms_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_start_accepted = result.start_accepted;
    assign o_request_start  = result.request_start;
    assign o_clear_start    = result.clear_start;
    assign o_send_valid     = result.send_valid;
    assign o_send_byte      = result.send_byte;
    assign o_request_stop   = result.request_stop;
    assign o_ack_action     = result.ack_action;
    assign o_rx_valid       = result.rx_valid;
    assign o_rx_byte        = result.rx_byte;
    assign o_rx_index       = result.rx_index;
    assign o_outcome        = result.outcome;

endmodule

### rtl/core/i2cms_ram.sv
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/i2cms_fifo.sv
// Small register queue; DEPTH is a power of two, at least 2.
module i2cms_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             is_full;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign is_full = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !is_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + AW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/core/i2cms_front.sv
module i2cms_front import i2cms_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [1:0] i_kind,
    input  logic [4:0] i_tx_slot,
    input  logic [7:0] i_tx_byte,
    input  logic [6:0] i_target_address,
    input  logic [5:0] i_write_length,
    input  logic [5:0] i_read_length,
    input  logic [7:0] i_status_code,
    input  logic [7:0] i_received_byte,
    input  logic       i_pop,
    output t_cmd       o_cmd,
    output logic       o_empty
);

    localparam int QCW = $clog2(IQ_DEPTH + 1);

    t_cmd                 cmd;
    logic [$bits(t_cmd)-1:0] q_data;
    logic [QCW-1:0]       q_count;

    always_comb begin
        cmd         = '0;
        cmd.tx_slot = i_tx_slot;
        cmd.tx_byte = i_tx_byte;
        cmd.address = i_target_address;
        cmd.rx_byte = i_received_byte;
        cmd.load_ok = ({27'd0, i_tx_slot} < 32'(BUFFER_DEPTH));

        case (i_kind)
            KIND_LOAD:  cmd.op = OP_LOAD;
            KIND_START: cmd.op = OP_START;
            KIND_EVENT: cmd.op = OP_EVENT;
            default:    cmd.op = OP_NONE;
        endcase

        // write length clipped to the buffer; a write clears the read length
        cmd.write_count = ({26'd0, i_write_length} > 32'(BUFFER_DEPTH)) ?
                          6'(BUFFER_DEPTH) : i_write_length;
        if (i_write_length != '0) begin
            cmd.read_count = '0;
        end else if (i_read_length > 6'(READ_MAX)) begin
            cmd.read_count = 6'(READ_MAX);
        end else begin
            cmd.read_count = i_read_length;
        end

        case (i_status_code)
            SC_START_SENT:            cmd.evt = EV_START;
            SC_SLAW_ACK, SC_DATA_ACK: cmd.evt = EV_TX;
            SC_SLAR_ACK:              cmd.evt = EV_RX_ADDR;
            SC_RX_ACK:                cmd.evt = EV_RX_DATA;
            SC_RX_NACK:               cmd.evt = EV_RX_LAST;
            default:                  cmd.evt = EV_OTHER;
        endcase
    end

    i2cms_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (IQ_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .i_pop   (i_pop),
        .o_data  (q_data),
        .o_empty (o_empty),
        .o_count (q_count)
    );

    assign o_full = (q_count == QCW'(IQ_DEPTH));
    assign o_cmd  = t_cmd'(q_data);

endmodule

### rtl/core/i2cms_back.sv
module i2cms_back import i2cms_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_valid,
    output logic    o_cmd_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int QCW = $clog2(OQ_DEPTH + 1);

    t_state     r_state, n_state;
    logic [6:0] r_addr, n_addr;
    logic [5:0] r_wcount, n_wcount;
    logic [5:0] r_wpos, n_wpos;
    logic [5:0] r_rcount, n_rcount;
    logic [5:0] r_rpos, n_rpos;

    logic       r_s2_valid;
    logic       r_s2_from_ram;
    t_result    r_s2_res;

    t_result    res, s2_out;
    logic       issue, busy, from_ram, ram_we, ram_re;
    logic [7:0] ram_rdata;
    logic [QCW-1:0] oq_count;
    logic [$bits(t_result)-1:0] oq_data;

    function automatic logic [1:0] ack_choice(input logic [5:0] pos, input logic [5:0] cnt);
        logic [1:0] a;
        if (cnt == '0) begin
            a = ACK_WITHDRAW;
        end else if ({1'b0, pos} + 7'd1 < {1'b0, cnt}) begin
            a = ACK_ASSERT;
        end else begin
            a = ACK_WITHDRAW;
        end
        return a;
    endfunction

    // room is reserved for the item in the second stage and the one issued now
    assign issue     = i_cmd_valid && ((32'(oq_count) + 32'(r_s2_valid)) < OQ_DEPTH);
    assign o_cmd_pop = issue;
    assign busy      = (r_state == S_BUSY);

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_wcount = r_wcount;
        n_wpos   = r_wpos;
        n_rcount = r_rcount;
        n_rpos   = r_rpos;
        res      = '0;
        from_ram = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;

        if (issue) begin
            case (i_cmd.op)
                OP_LOAD: begin
                    ram_we = !busy && i_cmd.load_ok;
                end
                OP_START: begin
                    if (!busy) begin
                        n_addr             = i_cmd.address;
                        n_wcount           = i_cmd.write_count;
                        n_wpos             = '0;
                        n_rcount           = i_cmd.read_count;
                        n_rpos             = '0;
                        n_state            = S_BUSY;
                        res.start_accepted = 1'b1;
                        res.request_start  = 1'b1;
                    end
                end
                OP_EVENT: begin
                    if (busy) begin
                        case (i_cmd.evt)
                            EV_START: begin
                                res.send_valid  = 1'b1;
                                res.send_byte   = {r_addr, (r_wcount == '0)};
                                res.clear_start = 1'b1;
                            end
                            EV_TX: begin
                                if (r_wpos < r_wcount) begin
                                    res.send_valid = 1'b1;
                                    from_ram       = 1'b1;
                                    ram_re         = 1'b1;
                                    n_wpos         = r_wpos + 6'd1;
                                end else begin
                                    res.request_stop = 1'b1;
                                    n_state          = S_DONE;
                                end
                            end
                            EV_RX_ADDR: begin
                                res.ack_action = ack_choice(r_rpos, r_rcount);
                            end
                            EV_RX_DATA, EV_RX_LAST: begin
                                if (r_rpos < r_rcount) begin
                                    res.rx_valid = 1'b1;
                                    res.rx_byte  = i_cmd.rx_byte;
                                    res.rx_index = r_rpos[4:0];
                                    n_rpos       = r_rpos + 6'd1;
                                end
                                if (i_cmd.evt == EV_RX_DATA) begin
                                    res.ack_action = ack_choice(n_rpos, r_rcount);
                                end else begin
                                    res.request_stop = 1'b1;
                                    n_state          = S_DONE;
                                end
                            end
                            default: begin
                                res.request_stop = 1'b1;
                                n_state          = S_ERROR;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
        res.outcome = outcome_of(n_state);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_addr     <= '0;
            r_wcount   <= '0;
            r_wpos     <= '0;
            r_rcount   <= '0;
            r_rpos     <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_wcount   <= n_wcount;
            r_wpos     <= n_wpos;
            r_rcount   <= n_rcount;
            r_rpos     <= n_rpos;
            r_s2_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_res      <= res;
        r_s2_from_ram <= from_ram;
    end

    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_tx_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_cmd.tx_slot)),
        .i_wdata (i_cmd.tx_byte),
        .i_re    (ram_re),
        .i_raddr (AW'(r_wpos)),
        .o_rdata (ram_rdata)
    );

    // buffered byte arrives from the RAM in the cycle after the decision
    always_comb begin
        s2_out = r_s2_res;
        if (r_s2_from_ram) begin
            s2_out.send_byte = ram_rdata;
        end
    end

    i2cms_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OQ_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid),
        .i_data  (s2_out),
        .i_pop   (i_pop),
        .o_data  (oq_data),
        .o_empty (o_empty),
        .o_count (oq_count)
    );

    assign o_result = t_result'(oq_data);

endmodule

### rtl/core/i2cms_checker.sv
`include "assert_macros.svh"

module i2cms_checker import i2cms_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic       o_start_accepted,
    input logic       o_request_start,
    input logic       o_clear_start,
    input logic       o_send_valid,
    input logic       o_request_stop,
    input logic [1:0] o_ack_action,
    input logic       o_rx_valid,
    input logic [1:0] o_outcome
);

    `ASSERT_NXT(a_result_holds, !empty && !pop, !empty, "result dropped while not popped")
    `ASSERT_IMP(a_start_busy, !empty && o_request_start, o_start_accepted && o_outcome == OUT_BUSY, "START request without accepted start")
    `ASSERT_IMP(a_clear_sends, !empty && o_clear_start, o_send_valid && !o_request_stop, "START clear without address byte")
    `ASSERT_IMP(a_stop_ends, !empty && o_request_stop, o_outcome == OUT_DONE || o_outcome == OUT_ERROR, "STOP while transaction still open")
    `ASSERT_IMP(a_rx_answered, !empty && o_rx_valid, o_request_stop || o_ack_action == ACK_ASSERT || o_ack_action == ACK_WITHDRAW, "received byte without ack or stop")

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_i2cms_checker (.*);

### test/i2c_master_transaction_sequencer_tb.sv
module i2c_master_transaction_sequencer_tb;
    import i2cms_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int ITEMS       = 700;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0] kind;
        logic [4:0] tx_slot;
        logic [7:0] tx_byte;
        logic [6:0] target_address;
        logic [5:0] write_length;
        logic [5:0] read_length;
        logic [7:0] status_code;
        logic [7:0] received_byte;
    } t_stim;

    // Tracks the transaction the sequencer is running and queues the engine
    // commands it should answer with, one per accepted item.
    class i2c_cmd_scoreboard;
        logic [1:0] status;
        logic [6:0] slave_addr;
        logic [7:0] tx_mem [BUFFER_DEPTH_DEF];
        bit         tx_loaded [BUFFER_DEPTH_DEF];
        int         wr_count;
        int         wr_pos;
        int         rd_count;
        int         rd_pos;
        t_result    pending_cmds [$];
        int         errors;

        function new();
            status     = OUT_IDLE;
            slave_addr = '0;
            wr_count   = 0;
            wr_pos     = 0;
            rd_count   = 0;
            rd_pos     = 0;
            errors     = 0;
            foreach (tx_loaded[i]) tx_loaded[i] = 1'b0;
        endfunction

        // number of buffer slots loaded in a row from slot 0
        function int loaded_prefix();
            int n;
            n = 0;
            while (n < BUFFER_DEPTH_DEF && tx_loaded[n]) n++;
            return n;
        endfunction

        function logic [1:0] ack_for_next();
            if (rd_count == 0 || rd_pos + 1 >= rd_count) return ACK_WITHDRAW;
            return ACK_ASSERT;
        endfunction

        function void hand_out(inout t_result r, input logic [7:0] data);
            if (rd_pos < rd_count) begin
                r.rx_valid = 1'b1;
                r.rx_byte  = data;
                r.rx_index = 5'(rd_pos);
                rd_pos++;
            end
        endfunction

        // returns 0 when the sequencer ignores a load, an event or an unused kind
        function bit note_item(t_stim s);
            t_result r;
            int      wl;
            int      rl;
            bit      used;
            r    = '0;
            used = 1'b1;
            case (s.kind)
                KIND_LOAD: begin
                    if (status != OUT_BUSY && s.tx_slot < BUFFER_DEPTH_DEF) begin
                        tx_mem[s.tx_slot]    = s.tx_byte;
                        tx_loaded[s.tx_slot] = 1'b1;
                    end else begin
                        used = 1'b0;
                    end
                end
                KIND_START: begin
                    if (status != OUT_BUSY) begin
                        wl = (s.write_length > BUFFER_DEPTH_DEF) ? BUFFER_DEPTH_DEF
                                                                 : s.write_length;
                        rl = (s.read_length > READ_MAX) ? READ_MAX : s.read_length;
                        slave_addr = s.target_address;
                        wr_count   = wl;
                        wr_pos     = 0;
                        rd_count   = (wl > 0) ? 0 : rl;
                        rd_pos     = 0;
                        status     = OUT_BUSY;
                        r.start_accepted = 1'b1;
                        r.request_start  = 1'b1;
                    end
                end
                KIND_EVENT: begin
                    if (status != OUT_BUSY) begin
                        used = 1'b0;
                    end else begin
                        case (s.status_code)
                            SC_START_SENT: begin
                                r.send_valid  = 1'b1;
                                r.send_byte   = {slave_addr, (wr_count == 0)};
                                r.clear_start = 1'b1;
                            end
                            SC_SLAW_ACK, SC_DATA_ACK: begin
                                if (wr_pos < wr_count) begin
                                    r.send_valid = 1'b1;
                                    r.send_byte  = tx_mem[wr_pos];
                                    wr_pos++;
                                end else begin
                                    r.request_stop = 1'b1;
                                    status         = OUT_DONE;
                                end
                            end
                            SC_SLAR_ACK: r.ack_action = ack_for_next();
                            SC_RX_ACK: begin
                                hand_out(r, s.received_byte);
                                r.ack_action = ack_for_next();
                            end
                            SC_RX_NACK: begin
                                hand_out(r, s.received_byte);
                                r.request_stop = 1'b1;
                                status         = OUT_DONE;
                            end
                            default: begin
                                r.request_stop = 1'b1;
                                status         = OUT_ERROR;
                            end
                        endcase
                    end
                end
                default: used = 1'b0;
            endcase
            r.outcome = status;
            pending_cmds.push_back(r);
            return used;
        endfunction

        function void diff(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_cmd(t_result got);
            t_result want;
            if (pending_cmds.size() == 0) begin
                $display("%0t: result with no item waiting, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_cmds.pop_front();
            diff("start_accepted", 8'(want.start_accepted), 8'(got.start_accepted));
            diff("request_start", 8'(want.request_start), 8'(got.request_start));
            diff("clear_start", 8'(want.clear_start), 8'(got.clear_start));
            diff("send_valid", 8'(want.send_valid), 8'(got.send_valid));
            diff("send_byte", want.send_byte, got.send_byte);
            diff("request_stop", 8'(want.request_stop), 8'(got.request_stop));
            diff("ack_action", 8'(want.ack_action), 8'(got.ack_action));
            diff("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
            diff("rx_byte", want.rx_byte, got.rx_byte);
            diff("rx_index", 8'(want.rx_index), 8'(got.rx_index));
            diff("outcome", 8'(want.outcome), 8'(got.outcome));
        endfunction
    endclass

    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       push             = 1'b0;
    logic       pop              = 1'b0;
    logic [1:0] i_kind           = '0;
    logic [4:0] i_tx_slot        = '0;
    logic [7:0] i_tx_byte        = '0;
    logic [6:0] i_target_address = '0;
    logic [5:0] i_write_length   = '0;
    logic [5:0] i_read_length    = '0;
    logic [7:0] i_status_code    = '0;
    logic [7:0] i_received_byte  = '0;
    logic       full;
    logic       empty;
    logic       o_start_accepted;
    logic       o_request_start;
    logic       o_clear_start;
    logic       o_send_valid;
    logic [7:0] o_send_byte;
    logic       o_request_stop;
    logic [1:0] o_ack_action;
    logic       o_rx_valid;
    logic [7:0] o_rx_byte;
    logic [4:0] o_rx_index;
    logic [1:0] o_outcome;

    i2c_cmd_scoreboard cmd_sb;
    int                counted = 0;
    bit                burst   = 1'b0;

    i2c_master_transaction_sequencer u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_kind           (i_kind),
        .i_tx_slot        (i_tx_slot),
        .i_tx_byte        (i_tx_byte),
        .i_target_address (i_target_address),
        .i_write_length   (i_write_length),
        .i_read_length    (i_read_length),
        .i_status_code    (i_status_code),
        .i_received_byte  (i_received_byte),
        .empty            (empty),
        .pop              (pop),
        .o_start_accepted (o_start_accepted),
        .o_request_start  (o_request_start),
        .o_clear_start    (o_clear_start),
        .o_send_valid     (o_send_valid),
        .o_send_byte      (o_send_byte),
        .o_request_stop   (o_request_stop),
        .o_ack_action     (o_ack_action),
        .o_rx_valid       (o_rx_valid),
        .o_rx_byte        (o_rx_byte),
        .o_rx_index       (o_rx_index),
        .o_outcome        (o_outcome)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_stim any_item();
        t_stim s;
        s.kind           = 2'($urandom_range(0, 3));
        s.tx_slot        = 5'($urandom);
        s.tx_byte        = 8'($urandom);
        s.target_address = 7'($urandom);
        s.write_length   = 6'($urandom);
        s.read_length    = 6'($urandom);
        s.status_code    = 8'($urandom);
        s.received_byte  = 8'($urandom);
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 8);
        if (r < 93) return $urandom_range(9, 32);
        return $urandom_range(33, 63);
    endfunction

    function automatic logic [7:0] junk_code();
        logic [7:0] c;
        do begin
            c = 8'($urandom);
        end while (c == SC_START_SENT || c == SC_SLAW_ACK || c == SC_DATA_ACK ||
                   c == SC_SLAR_ACK || c == SC_RX_ACK || c == SC_RX_NACK);
        return c;
    endfunction

    function automatic t_result seen_cmd();
        t_result r;
        r.start_accepted = o_start_accepted;
        r.request_start  = o_request_start;
        r.clear_start    = o_clear_start;
        r.send_valid     = o_send_valid;
        r.send_byte      = o_send_byte;
        r.request_stop   = o_request_stop;
        r.ack_action     = o_ack_action;
        r.rx_valid       = o_rx_valid;
        r.rx_byte        = o_rx_byte;
        r.rx_index       = o_rx_index;
        r.outcome        = o_outcome;
        return r;
    endfunction

    task automatic put(input t_stim s);
        int lim;
        int gap;
        // never let a write run past the loaded part of the buffer
        if (s.kind == KIND_START && cmd_sb.status != OUT_BUSY && s.write_length != 0) begin
            lim = (s.write_length > BUFFER_DEPTH_DEF) ? BUFFER_DEPTH_DEF : s.write_length;
            if (lim > cmd_sb.loaded_prefix()) s.write_length = 6'(cmd_sb.loaded_prefix());
        end
        push             <= 1'b1;
        i_kind           <= s.kind;
        i_tx_slot        <= s.tx_slot;
        i_tx_byte        <= s.tx_byte;
        i_target_address <= s.target_address;
        i_write_length   <= s.write_length;
        i_read_length    <= s.read_length;
        i_status_code    <= s.status_code;
        i_received_byte  <= s.received_byte;
        do @(posedge i_clk); while (full);
        if (cmd_sb.note_item(s)) counted++;
        if ($urandom_range(0, 39) == 0) burst = !burst;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load(input logic [4:0] slot, input logic [7:0] data);
        t_stim s;
        s         = any_item();
        s.kind    = KIND_LOAD;
        s.tx_slot = slot;
        s.tx_byte = data;
        put(s);
    endtask

    task automatic start_txn(input logic [6:0] addr, input logic [5:0] wl,
                             input logic [5:0] rl);
        t_stim s;
        s                = any_item();
        s.kind           = KIND_START;
        s.target_address = addr;
        s.write_length   = wl;
        s.read_length    = rl;
        put(s);
    endtask

    task automatic ev(input logic [7:0] code, input logic [7:0] data);
        t_stim s;
        s               = any_item();
        s.kind          = KIND_EVENT;
        s.status_code   = code;
        s.received_byte = data;
        put(s);
    endtask

    // occasional stray item in the middle of a transaction
    task automatic disturb();
        if ($urandom_range(0, 29) == 0) put(any_item());
    endtask

    task automatic run_txn();
        int wl;
        int rl;
        int n;
        int i;
        bit rd;
        if (cmd_sb.status == OUT_BUSY && $urandom_range(0, 3) != 0)
            ev(junk_code(), 8'($urandom));
        repeat ($urandom_range(0, 3)) load(5'($urandom), 8'($urandom));
        rd = 1'($urandom_range(0, 1));
        wl = rd ? 0 : pick_len();
        if (!rd && wl == 0) wl = 1;
        rl = pick_len();
        start_txn(7'($urandom), 6'(wl), 6'(rl));
        disturb();
        ev(SC_START_SENT, 8'($urandom));
        if (!rd) begin
            n = (wl > BUFFER_DEPTH_DEF) ? BUFFER_DEPTH_DEF : wl;
            // one event per byte plus the one that ends in STOP
            for (i = 0; i <= n; i++) begin
                disturb();
                if ($urandom_range(0, 79) == 0) return;
                ev($urandom_range(0, 1) ? SC_SLAW_ACK : SC_DATA_ACK, 8'($urandom));
            end
        end else begin
            n = (rl > READ_MAX) ? READ_MAX : rl;
            ev(SC_SLAR_ACK, 8'($urandom));
            for (i = 1; i < n; i++) begin
                disturb();
                if ($urandom_range(0, 79) == 0) return;
                ev(SC_RX_ACK, 8'($urandom));
            end
            if ($urandom_range(0, 7) == 0) ev(SC_RX_ACK, 8'($urandom));
            ev(SC_RX_NACK, 8'($urandom));
        end
    endtask

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : drain
        int hold;
        bit calm;
        bit held_once;
        bit next_pop;
        int r;
        hold      = 0;
        calm      = 1'b0;
        held_once = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) cmd_sb.check_cmd(seen_cmd());
            // long hold-off so the block fills up and pushes back
            if (!held_once && counted >= HOLD_AT) begin
                held_once = 1'b1;
                hold      = HOLD_CYCLES;
            end
            if ($urandom_range(0, 59) == 0) calm = !calm;
            if (!i_rst_n) begin
                next_pop = 1'b0;
            end else if (hold > 0) begin
                next_pop = 1'b0;
                hold--;
            end else if (calm) begin
                next_pop = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    next_pop = 1'b1;
                end else begin
                    next_pop = 1'b0;
                    hold     = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                end
            end
            pop <= next_pop;
        end
    end

    initial begin : stimulus
        t_stim s;
        int    i;
        cmd_sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // write of two bytes, with a refused start and an ignored load while busy
        load(5'd0, 8'h00);
        load(5'd1, 8'hFF);
        load(5'd31, 8'h5A);
        start_txn(7'h7F, 6'd2, 6'd63);
        start_txn(7'h2A, 6'd0, 6'd5);
        load(5'd1, 8'h33);
        ev(SC_START_SENT, 8'h00);
        ev(SC_SLAW_ACK, 8'hFF);
        ev(SC_DATA_ACK, 8'h00);
        ev(SC_DATA_ACK, 8'hFF);
        // read of two with a surplus byte
        start_txn(7'h00, 6'd0, 6'd2);
        ev(SC_START_SENT, 8'h00);
        ev(SC_SLAR_ACK, 8'h00);
        ev(SC_RX_ACK, 8'hFF);
        ev(SC_RX_ACK, 8'h12);
        ev(SC_RX_NACK, 8'h00);
        // zero-length read
        start_txn(7'h55, 6'd0, 6'd0);
        ev(SC_SLAR_ACK, 8'h00);
        ev(SC_RX_NACK, 8'hAA);
        // oversized read cut short by an unknown code, then an event while idle and an unused kind
        start_txn(7'h01, 6'd0, 6'd63);
        ev(SC_START_SENT, 8'hFF);
        ev(8'hFF, 8'h00);
        ev(SC_RX_NACK, 8'h77);
        s      = any_item();
        s.kind = KIND_UNUSED;
        put(s);

        for (i = 0; i < BUFFER_DEPTH_DEF; i++) load(5'(i), 8'($urandom));
        while (counted < ITEMS) begin
            if ($urandom_range(0, 9) < 8) run_txn();
            else repeat ($urandom_range(1, 4)) put(any_item());
        end
        if (push) push <= 1'b0;

        while (cmd_sb.pending_cmds.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (cmd_sb.errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
